@@ hw/rtl/itc_pkg.sv @@
// Package for the three-counter interval timer.
// Holds the port addresses, operation codes, load phases and the counter command struct.
// Depends on nothing; the top level, the counter and the testbench use it.
package itc_pkg;

   localparam int NumCountersDefault = 3;

   localparam logic [15:0] ControlPort       = 16'h00a6;
   localparam logic [15:0] DataPort          = 16'h00a2;
   localparam logic [15:0] TickDecReset      = 16'd18432;
   localparam logic [1:0]  SelectNone        = 2'd3;

   localparam int CsrAddrW = 3;
   localparam int CsrDataW = 32;
   localparam logic [0:0] CsrIdxTickDec = 1'b0;

   typedef enum logic [1:0] {
      FUNC_WRITE = 2'd0,
      FUNC_TICK  = 2'd1,
      FUNC_POLL  = 2'd2,
      FUNC_CLEAR = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      PHASE_LOW  = 2'd0,
      PHASE_HIGH = 2'd1,
      PHASE_DONE = 2'd2
   } phase_type;

   typedef struct packed {
      logic       clear;
      logic       load_low;
      logic       load_high;
      logic       tick;
      logic       poll_clear;
      logic [7:0] data;
   } cnt_cmd_type;

endpackage

@@ hw/rtl/itc_req_if.sv @@
// Input channel of the interval timer: one operation per transfer.
// Depends on nothing.
interface itc_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  func;
   logic [15:0] port_address;
   logic [7:0]  write_data;

   modport source (output valid, output func, output port_address, output write_data,
                   input ready);
   modport sink (input valid, input func, input port_address, input write_data,
                 output ready);
endinterface

@@ hw/rtl/itc_rsp_if.sv @@
// Result channel of the interval timer: the two interrupt flags of one operation.
// Depends on nothing.
interface itc_rsp_if;
   logic valid;
   logic ready;
   logic irq0_raise;
   logic irq1_raise;

   modport source (output valid, output irq0_raise, output irq1_raise, input ready);
   modport sink (input valid, input irq0_raise, input irq1_raise, output ready);
endinterface

@@ hw/rtl/interval_timer_three_counters.sv @@
// Top level of the interval timer: input register, port decode, counters, result register.
// Depends on itc_pkg, itc_req_if, itc_rsp_if and itc_counter.
//
//   Channel   Ports        Direction  Content
//   input     req_ch.*     in         func, port_address, write_data
//   result    rsp_ch.*     out        irq0_raise, irq1_raise
//   config    csr_*        in         tick_decrement at byte address 0
//
// An operation passes through the input register, then through the decode and counter
// update into the result register.
// A new operation is taken every cycle unless the result is held; all counters update in parallel.
// Reset clears all counts, reload values, pending flags and the selection, and sets the tick decrement to its default.
// When the result is not taken, an operation in the input register holds there and req_ch.ready drops.
module interval_timer_three_counters #(
   parameter int NUM_COUNTERS = itc_pkg::NumCountersDefault
) (
   input  logic                          clock,
   input  logic                          reset,
   itc_req_if.sink                       req_ch,
   itc_rsp_if.source                     rsp_ch,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [itc_pkg::CsrAddrW-1:0]  csr_paddr,
   input  logic [itc_pkg::CsrDataW-1:0]  csr_pwdata,
   output logic [itc_pkg::CsrDataW-1:0]  csr_prdata,
   output logic                          csr_pready
);

   logic                  in_valid_ff;
   itc_pkg::func_type     in_func_ff;
   logic [15:0]           in_addr_ff;
   logic [7:0]            in_data_ff;
   logic                  rsp_valid_ff;
   logic                  irq0_ff, irq1_ff;
   logic [15:0]           tick_dec_ff;
   logic [1:0]            sel_ff, sel_in;
   logic                  sel_valid_ff, sel_valid_in;
   itc_pkg::phase_type    phase_ff, phase_in;

   logic                  advance;
   logic                  is_ctrl, is_data, is_tick, is_poll, is_clear;
   logic [1:0]            sel_new;
   logic                  sel_ok, data_ok;
   logic [NUM_COUNTERS-1:0] pending;
   logic                  pend1, pend2;
   logic                  csr_write;

   assign advance = in_valid_ff && (!rsp_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ch.ready) begin
         in_valid_ff <= req_ch.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.ready && req_ch.valid) begin
         in_func_ff <= itc_pkg::func_type'(req_ch.func);
         in_addr_ff <= req_ch.port_address;
         in_data_ff <= req_ch.write_data;
      end
   end

   assign is_ctrl  = advance && (in_func_ff == itc_pkg::FUNC_WRITE)
                     && (in_addr_ff == itc_pkg::ControlPort);
   assign is_data  = advance && (in_func_ff == itc_pkg::FUNC_WRITE)
                     && (in_addr_ff == itc_pkg::DataPort);
   assign is_tick  = advance && (in_func_ff == itc_pkg::FUNC_TICK);
   assign is_poll  = advance && (in_func_ff == itc_pkg::FUNC_POLL);
   assign is_clear = advance && (in_func_ff == itc_pkg::FUNC_CLEAR);

   assign sel_new = in_data_ff[7:6];
   assign sel_ok  = (sel_new != itc_pkg::SelectNone) && (32'(sel_new) < NUM_COUNTERS);
   assign data_ok = is_data && sel_valid_ff && (32'(sel_ff) < NUM_COUNTERS);

   always_comb begin
      sel_in       = sel_ff;
      sel_valid_in = sel_valid_ff;
      phase_in     = phase_ff;
      if (is_ctrl) begin
         if (sel_ok) begin
            sel_in       = sel_new;
            sel_valid_in = 1'b1;
            phase_in     = itc_pkg::PHASE_LOW;
         end else begin
            sel_valid_in = 1'b0;
         end
      end else if (data_ok) begin
         case (phase_ff)
            itc_pkg::PHASE_LOW:  phase_in = itc_pkg::PHASE_HIGH;
            itc_pkg::PHASE_HIGH: phase_in = itc_pkg::PHASE_DONE;
            default:             phase_in = phase_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sel_ff       <= '0;
         sel_valid_ff <= 1'b0;
         phase_ff     <= itc_pkg::PHASE_LOW;
      end else begin
         sel_ff       <= sel_in;
         sel_valid_ff <= sel_valid_in;
         phase_ff     <= phase_in;
      end
   end

   for (genvar i = 0; i < NUM_COUNTERS; i++) begin : g_counter
      itc_pkg::cnt_cmd_type cmd;

      always_comb begin
         cmd.clear      = (is_ctrl && sel_ok && (32'(sel_new) == i)) || is_clear;
         cmd.load_low   = data_ok && (phase_ff == itc_pkg::PHASE_LOW)
                          && (32'(sel_ff) == i);
         cmd.load_high  = data_ok && (phase_ff == itc_pkg::PHASE_HIGH)
                          && (32'(sel_ff) == i);
         cmd.tick       = is_tick;
         cmd.poll_clear = is_poll && ((i == 1) || (i == 2));
         cmd.data       = in_data_ff;
      end

      itc_counter u_counter (
         .clock          (clock),
         .reset          (reset),
         .cmd            (cmd),
         .tick_decrement (tick_dec_ff),
         .pending        (pending[i])
      );
   end

   assign pend1 = (NUM_COUNTERS > 1) && pending[1 % NUM_COUNTERS];
   assign pend2 = (NUM_COUNTERS > 2) && pending[2 % NUM_COUNTERS];

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         irq0_ff <= is_poll && pend1;
         irq1_ff <= is_poll && pend2;
      end
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.irq0_raise = irq0_ff;
   assign rsp_ch.irq1_raise = irq1_ff;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite
                       && (csr_paddr[itc_pkg::CsrAddrW-1] == itc_pkg::CsrIdxTickDec);

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_dec_ff <= itc_pkg::TickDecReset;
      end else if (csr_write) begin
         tick_dec_ff <= csr_pwdata[15:0];
      end
   end

   always_comb begin
      if (csr_paddr[itc_pkg::CsrAddrW-1] == itc_pkg::CsrIdxTickDec) begin
         csr_prdata = {{(itc_pkg::CsrDataW-16){1'b0}}, tick_dec_ff};
      end else begin
         csr_prdata = '0;
      end
   end

endmodule

@@ hw/rtl/itc_counter.sv @@
// One down counter of the interval timer: reload value, working count and pending flag.
// Depends on itc_pkg for the command struct.
module itc_counter (
   input  logic                clock,
   input  logic                reset,
   input  itc_pkg::cnt_cmd_type cmd,
   input  logic [15:0]         tick_decrement,
   output logic                pending
);

   logic [15:0] reload_ff, reload_in;
   logic [15:0] count_ff, count_in;
   logic        pending_ff, pending_in;
   logic [15:0] high_value;

   assign high_value = reload_ff + {cmd.data, 8'h00};

   always_comb begin
      reload_in  = reload_ff;
      count_in   = count_ff;
      pending_in = pending_ff;
      if (cmd.clear) begin
         reload_in = '0;
         count_in  = '0;
      end else if (cmd.load_low) begin
         reload_in = {8'h00, cmd.data};
      end else if (cmd.load_high) begin
         reload_in = high_value;
         count_in  = high_value;
      end else if (cmd.tick && (reload_ff != '0)) begin
         if (count_ff <= tick_decrement) begin
            count_in   = reload_ff;
            pending_in = 1'b1;
         end else begin
            count_in = count_ff - tick_decrement;
         end
      end else if (cmd.poll_clear) begin
         pending_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         reload_ff  <= '0;
         count_ff   <= '0;
         pending_ff <= 1'b0;
      end else begin
         reload_ff  <= reload_in;
         count_ff   <= count_in;
         pending_ff <= pending_in;
      end
   end

   assign pending = pending_ff;

endmodule

@@ tb/interval_timer_three_counters_tb.sv @@
// Testbench for the three-counter interval timer: directed, backpressure and random
// operation streams, each result checked against a predictor of the counters.
// Depends on itc_pkg, itc_req_if, itc_rsp_if and interval_timer_three_counters.
module interval_timer_three_counters_tb;

   localparam logic [itc_pkg::CsrAddrW-1:0] TickStepAddr =
      itc_pkg::CsrAddrW'(4 * itc_pkg::CsrIdxTickDec);

   typedef struct packed {
      logic irq0;
      logic irq1;
   } irq_flags_type;

   logic                         clock = 1'b0;
   logic                         reset;
   logic                         csr_psel;
   logic                         csr_penable;
   logic                         csr_pwrite;
   logic [itc_pkg::CsrAddrW-1:0] csr_paddr;
   logic [itc_pkg::CsrDataW-1:0] csr_pwdata;
   logic [itc_pkg::CsrDataW-1:0] csr_prdata;
   logic                         csr_pready;

   itc_req_if req_ch();
   itc_rsp_if rsp_ch();

   interval_timer_three_counters dut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   logic [15:0]        tick_step;
   logic [15:0]        timer_reload [3];
   logic signed [31:0] timer_count [3];
   logic               timer_pending [3];
   logic [1:0]         sel_counter;
   logic               sel_valid;
   itc_pkg::phase_type load_phase;

   irq_flags_type irq_expected [$];
   irq_flags_type want_flags;

   int  errors = 0;
   int  ops_sent = 0;
   int  results_checked = 0;
   int  irq_seen = 0;
   int  step_settings = 1;
   bit  pacing_on = 1'b1;
   int  rsp_hold_len = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #4000000;
      $display("TB_ERROR");
      $finish;
   end

   function automatic void predict_timer_op(input itc_pkg::func_type op,
                                            input logic [15:0] addr,
                                            input logic [7:0] data,
                                            output irq_flags_type flags);
      logic [15:0] merged;
      int          i;
      flags = '0;
      case (op)
         itc_pkg::FUNC_WRITE: begin
            if (addr == itc_pkg::ControlPort) begin
               if (data[7:6] != itc_pkg::SelectNone) begin
                  sel_counter = data[7:6];
                  sel_valid = 1'b1;
                  timer_reload[data[7:6]] = '0;
                  timer_count[data[7:6]] = '0;
                  load_phase = itc_pkg::PHASE_LOW;
               end else begin
                  sel_valid = 1'b0;
               end
            end else if (addr == itc_pkg::DataPort && sel_valid) begin
               if (load_phase == itc_pkg::PHASE_LOW) begin
                  timer_reload[sel_counter] = {8'h00, data};
                  load_phase = itc_pkg::PHASE_HIGH;
               end else if (load_phase == itc_pkg::PHASE_HIGH) begin
                  merged = timer_reload[sel_counter] + {data, 8'h00};
                  timer_reload[sel_counter] = merged;
                  timer_count[sel_counter] = {16'h0000, merged};
                  load_phase = itc_pkg::PHASE_DONE;
               end
            end
         end
         itc_pkg::FUNC_TICK: begin
            for (i = 0; i < 3; i++) begin
               if (timer_reload[i] != 0) begin
                  timer_count[i] = timer_count[i] - $signed({16'h0000, tick_step});
                  if (timer_count[i] <= 0) begin
                     timer_count[i] = {16'h0000, timer_reload[i]};
                     timer_pending[i] = 1'b1;
                  end
               end
            end
         end
         itc_pkg::FUNC_POLL: begin
            flags.irq0 = timer_pending[1];
            flags.irq1 = timer_pending[2];
            timer_pending[1] = 1'b0;
            timer_pending[2] = 1'b0;
         end
         default: begin
            for (i = 0; i < 3; i++) begin
               timer_reload[i] = '0;
               timer_count[i] = '0;
            end
         end
      endcase
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (!pacing_on || r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic logic [15:0] pick_reload();
      int span;
      int r;
      span = (tick_step == 0) ? 4 : 4 * tick_step;
      if (span > 65535) span = 65535;
      r = $urandom_range(0, 99);
      if (r < 70) return 16'($urandom_range(1, span));
      if (r < 85) begin
         case ($urandom_range(0, 4))
            0: return 16'h0001;
            1: return 16'hffff;
            2: return 16'h0100;
            3: return 16'h00ff;
            default: return 16'h0000;
         endcase
      end
      return 16'($urandom);
   endfunction

   // Called right after a rising edge; returns right after the edge of the transfer
   // or after the gap that follows it.
   task automatic send_op(input itc_pkg::func_type op, input logic [15:0] addr,
                          input logic [7:0] data);
      irq_flags_type flags;
      int            gap;
      if (!req_ch.valid) req_ch.valid <= 1'b1;
      req_ch.func <= op;
      req_ch.port_address <= addr;
      req_ch.write_data <= data;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      predict_timer_op(op, addr, data, flags);
      irq_expected.push_back(flags);
      ops_sent++;
      gap = pick_gap();
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_plain(input itc_pkg::func_type op);
      send_op(op, 16'($urandom), 8'($urandom));
   endtask

   task automatic wait_idle();
      if (req_ch.valid) req_ch.valid <= 1'b0;
      while (irq_expected.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_tick_step(input logic [15:0] step);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= TickStepAddr;
      csr_pwdata <= {16'h0000, step};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      tick_step = step;
      step_settings++;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      if (csr_prdata[15:0] !== step) begin
         errors++;
         $display("%0t: tick step read back: expected %0d, actual %0d", $time, step,
                  csr_prdata[15:0]);
      end
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic program_counter();
      logic [1:0]  which;
      logic [7:0]  junk;
      logic [15:0] value;
      which = 2'($urandom_range(0, 2));
      junk = 8'($urandom);
      value = pick_reload();
      send_op(itc_pkg::FUNC_WRITE, itc_pkg::ControlPort, {which, junk[5:0]});
      send_op(itc_pkg::FUNC_WRITE, itc_pkg::DataPort, value[7:0]);
      send_op(itc_pkg::FUNC_WRITE, itc_pkg::DataPort, value[15:8]);
   endtask

   task automatic send_broken_program();
      logic [7:0]  ctrl;
      logic [15:0] value;
      ctrl = 8'($urandom);
      value = pick_reload();
      case ($urandom_range(0, 4))
         0: send_op(itc_pkg::FUNC_WRITE, itc_pkg::ControlPort, ctrl);
         1: begin
            ctrl[7:6] = 2'($urandom_range(0, 2));
            send_op(itc_pkg::FUNC_WRITE, itc_pkg::ControlPort, ctrl);
            send_op(itc_pkg::FUNC_WRITE, itc_pkg::DataPort, value[7:0]);
         end
         2: begin
            send_op(itc_pkg::FUNC_WRITE, itc_pkg::ControlPort,
                    {itc_pkg::SelectNone, ctrl[5:0]});
            send_op(itc_pkg::FUNC_WRITE, itc_pkg::DataPort, value[7:0]);
            send_op(itc_pkg::FUNC_WRITE, itc_pkg::DataPort, value[15:8]);
         end
         3: begin
            program_counter();
            send_op(itc_pkg::FUNC_WRITE, itc_pkg::DataPort, ctrl);
         end
         default: begin
            ctrl[7:6] = 2'($urandom_range(0, 2));
            send_op(itc_pkg::FUNC_WRITE, itc_pkg::ControlPort, ctrl);
            send_op(itc_pkg::FUNC_WRITE, itc_pkg::DataPort, value[7:0]);
            send_plain(itc_pkg::FUNC_CLEAR);
            send_op(itc_pkg::FUNC_WRITE, itc_pkg::DataPort, value[15:8]);
         end
      endcase
   endtask

   task automatic send_stray_write();
      logic [15:0] addr;
      addr = 16'($urandom);
      case ($urandom_range(0, 2))
         0: addr = itc_pkg::ControlPort ^ (16'h0001 << $urandom_range(0, 15));
         1: addr = itc_pkg::DataPort ^ (16'h0001 << $urandom_range(0, 15));
         default: ;
      endcase
      send_op(itc_pkg::FUNC_WRITE, addr, 8'($urandom));
   endtask

   task automatic test_directed();
      send_op(itc_pkg::FUNC_WRITE, itc_pkg::ControlPort, 8'h40);
      send_op(itc_pkg::FUNC_WRITE, itc_pkg::DataPort, 8'h00);
      send_op(itc_pkg::FUNC_WRITE, itc_pkg::DataPort, 8'h48);
      send_op(itc_pkg::FUNC_WRITE, itc_pkg::DataPort, 8'h55);
      send_op(itc_pkg::FUNC_WRITE, itc_pkg::ControlPort, 8'hbf);
      send_op(itc_pkg::FUNC_WRITE, itc_pkg::DataPort, 8'hff);
      send_op(itc_pkg::FUNC_WRITE, itc_pkg::DataPort, 8'hff);
      send_op(itc_pkg::FUNC_WRITE, itc_pkg::ControlPort, 8'h3f);
      send_op(itc_pkg::FUNC_WRITE, itc_pkg::DataPort, 8'h01);
      send_op(itc_pkg::FUNC_WRITE, itc_pkg::DataPort, 8'h00);
      send_op(itc_pkg::FUNC_WRITE, itc_pkg::ControlPort, 8'hc0);
      send_op(itc_pkg::FUNC_WRITE, itc_pkg::DataPort, 8'h12);
      send_op(itc_pkg::FUNC_WRITE, 16'hffff, 8'hff);
      send_op(itc_pkg::FUNC_WRITE, 16'h00a7, 8'h40);
      send_op(itc_pkg::FUNC_TICK, 16'hffff, 8'hff);
      send_op(itc_pkg::FUNC_POLL, 16'h0000, 8'h00);
      repeat (3) send_op(itc_pkg::FUNC_TICK, 16'h0000, 8'h00);
      send_op(itc_pkg::FUNC_POLL, 16'hffff, 8'hff);
      send_op(itc_pkg::FUNC_POLL, 16'h0000, 8'h00);
      send_op(itc_pkg::FUNC_CLEAR, 16'hffff, 8'hff);
      send_op(itc_pkg::FUNC_TICK, 16'h0000, 8'h00);
      send_op(itc_pkg::FUNC_POLL, 16'h0000, 8'h00);
   endtask

   // The result side holds off while ticks and polls keep coming, so the input stalls.
   task automatic test_result_backpressure();
      int k;
      wait_idle();
      pacing_on = 1'b0;
      send_op(itc_pkg::FUNC_WRITE, itc_pkg::ControlPort, 8'h40);
      send_op(itc_pkg::FUNC_WRITE, itc_pkg::DataPort, 8'h00);
      send_op(itc_pkg::FUNC_WRITE, itc_pkg::DataPort, 8'h90);
      rsp_hold_len = 80;
      for (k = 0; k < 30; k++) begin
         if (k % 3 == 2) send_plain(itc_pkg::FUNC_POLL);
         else send_plain(itc_pkg::FUNC_TICK);
      end
      wait_idle();
      pacing_on = 1'b1;
   endtask

   task automatic test_random_mix(input int n_ops);
      int stop_at;
      int r;
      stop_at = ops_sent + n_ops;
      while (ops_sent < stop_at) begin
         r = $urandom_range(0, 99);
         if (r < 30) program_counter();
         else if (r < 55) repeat ($urandom_range(1, 6)) send_plain(itc_pkg::FUNC_TICK);
         else if (r < 72) send_plain(itc_pkg::FUNC_POLL);
         else if (r < 75) send_plain(itc_pkg::FUNC_CLEAR);
         else if (r < 86) send_broken_program();
         else if (r < 97) send_stray_write();
         else wait_idle();
      end
   endtask

   task automatic test_random_at_step(input logic [15:0] step, input int n_ops,
                                      input bit paced);
      wait_idle();
      write_tick_step(step);
      pacing_on = paced;
      test_random_mix(n_ops);
      pacing_on = 1'b1;
   endtask

   initial begin
      int stall_left;
      stall_left = 0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_hold_len > 0) begin
            stall_left = rsp_hold_len;
            rsp_hold_len = 0;
         end else if (stall_left == 0 && pacing_on && $urandom_range(0, 99) < 25) begin
            stall_left = pick_gap();
         end
         if (stall_left > 0) begin
            rsp_ch.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (irq_expected.size() == 0) begin
            errors++;
            $display("%0t: unexpected result: expected none, actual irq0=%b irq1=%b", $time,
                     rsp_ch.irq0_raise, rsp_ch.irq1_raise);
         end else begin
            want_flags = irq_expected.pop_front();
            results_checked++;
            if (want_flags.irq0 || want_flags.irq1) irq_seen++;
            if (rsp_ch.irq0_raise !== want_flags.irq0) begin
               errors++;
               $display("%0t: irq0_raise: expected %b, actual %b", $time, want_flags.irq0,
                        rsp_ch.irq0_raise);
            end
            if (rsp_ch.irq1_raise !== want_flags.irq1) begin
               errors++;
               $display("%0t: irq1_raise: expected %b, actual %b", $time, want_flags.irq1,
                        rsp_ch.irq1_raise);
            end
         end
      end
   end

   initial begin
      int i;
      tick_step = itc_pkg::TickDecReset;
      for (i = 0; i < 3; i++) begin
         timer_reload[i] = '0;
         timer_count[i] = '0;
         timer_pending[i] = 1'b0;
      end
      sel_counter = '0;
      sel_valid = 1'b0;
      load_phase = itc_pkg::PHASE_LOW;
      reset <= 1'b1;
      req_ch.valid <= 1'b0;
      req_ch.func <= itc_pkg::FUNC_WRITE;
      req_ch.port_address <= '0;
      req_ch.write_data <= '0;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_paddr <= '0;
      csr_pwdata <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_result_backpressure();
      test_random_mix(180);
      test_random_at_step(16'hffff, 150, 1'b1);
      test_random_at_step(16'h0001, 150, 1'b0);
      test_random_at_step(16'h0000, 120, 1'b1);
      test_random_at_step(16'($urandom_range(1, 65535)), 170, 1'b1);
      test_random_at_step(16'($urandom_range(2, 600)), 170, 1'b1);

      wait_idle();
      repeat (10) @(posedge clock);
      $display("Ran %0d timer operations over %0d tick step settings.", ops_sent,
               step_settings);
      $display("Checked %0d results, %0d of them with an interrupt flag set.",
               results_checked, irq_seen);
      if (errors == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
